// ----- hdl/rvm_pkg.sv -----
package rvm_pkg;

    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned REG_AW   = 5;

    // opcodes
    localparam logic [7:0] OPC_NOP  = 8'd0;
    localparam logic [7:0] OPC_LI   = 8'd1;
    localparam logic [7:0] OPC_ADD  = 8'd2;
    localparam logic [7:0] OPC_SUB  = 8'd3;
    localparam logic [7:0] OPC_MUL  = 8'd4;
    localparam logic [7:0] OPC_DIV  = 8'd5;
    localparam logic [7:0] OPC_MOD  = 8'd6;
    localparam logic [7:0] OPC_J    = 8'd7;
    localparam logic [7:0] OPC_JEQ  = 8'd8;
    localparam logic [7:0] OPC_JNE  = 8'd9;
    localparam logic [7:0] OPC_JLT  = 8'd10;
    localparam logic [7:0] OPC_JGT  = 8'd11;
    localparam logic [7:0] OPC_JLE  = 8'd12;
    localparam logic [7:0] OPC_JGE  = 8'd13;
    localparam logic [7:0] OPC_JR   = 8'd14;
    localparam logic [7:0] OPC_JREQ = 8'd15;
    localparam logic [7:0] OPC_JRNE = 8'd16;
    localparam logic [7:0] OPC_JRLT = 8'd17;
    localparam logic [7:0] OPC_JRGT = 8'd18;
    localparam logic [7:0] OPC_JRLE = 8'd19;
    localparam logic [7:0] OPC_JRGE = 8'd20;
    localparam logic [7:0] OPC_MOV  = 8'd21;
    localparam logic [7:0] OPC_SYS  = 8'd22;

    localparam logic [7:0] SYS_PRINT = 8'd0;

    // shared unit operations
    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_MUL = 4'd2;
    localparam logic [3:0] ALU_DIV = 4'd3;
    localparam logic [3:0] ALU_MOD = 4'd4;
    localparam logic [3:0] ALU_EQ  = 4'd5;
    localparam logic [3:0] ALU_NE  = 4'd6;
    localparam logic [3:0] ALU_LT  = 4'd7;
    localparam logic [3:0] ALU_GT  = 4'd8;
    localparam logic [3:0] ALU_LE  = 4'd9;
    localparam logic [3:0] ALU_GE  = 4'd10;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] field_a;
        logic [7:0] field_b;
        logic [7:0] field_c;
    } t_in_req;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               halted;
        logic               print_valid;
        logic [4:0]         print_reg;
        logic signed [31:0] print_value;
        logic               unknown_op;
    } t_out_rsp;

    typedef struct packed {
        logic       start;
        logic [3:0] op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic flag;
    } t_alu_rsp;

    typedef struct packed {
        logic              rd0_en;
        logic [REG_AW-1:0] rd0_addr;
        logic              rd1_en;
        logic [REG_AW-1:0] rd1_addr;
        logic              wr_en;
        logic [REG_AW-1:0] wr_addr;
    } t_rf_ctl;

endpackage

// ----- hdl/rvm_regfile.sv -----
module rvm_regfile
    import rvm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rf_ctl     i_ctl,
    input  logic [31:0] i_wdata,
    output logic [31:0] o_rdata0,
    output logic [31:0] o_rdata1
);

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [31:0]         r_rdata0;
    logic [31:0]         r_rdata1;
    logic                r_rvld0;
    logic                r_rvld1;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_ctl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wdata;
        end
        if (i_ctl.rd0_en) begin
            r_rdata0 <= r_mem[i_ctl.rd0_addr];
            r_rvld0  <= r_vld[i_ctl.rd0_addr];
        end
        if (i_ctl.rd1_en) begin
            r_rdata1 <= r_mem[i_ctl.rd1_addr];
            r_rvld1  <= r_vld[i_ctl.rd1_addr];
        end
    end

    assign o_rdata0 = r_rvld0 ? r_rdata0 : '0;
    assign o_rdata1 = r_rvld1 ? r_rdata1 : '0;

endmodule

// ----- hdl/rvm_alu.sv -----
module rvm_alu
    import rvm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_req    i_req,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_alu_rsp    o_rsp,
    output logic [31:0] o_result
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_FIX  = 2'd2;

    logic [1:0]  r_state;
    logic        r_done;
    logic        r_flag;
    logic [31:0] r_res;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_is_mod;

    logic [31:0] abs_a;
    logic [31:0] abs_b;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        fits;
    logic [31:0] n_rem;
    logic [31:0] n_quo;
    logic        div_go;
    logic        cmp_flag;

    assign abs_a  = i_a[31] ? (32'd0 - i_a) : i_a;
    assign abs_b  = i_b[31] ? (32'd0 - i_b) : i_b;
    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign fits   = !diff[32];
    assign n_rem  = fits ? diff[31:0] : rem_sh[31:0];
    assign n_quo  = {r_quo[30:0], fits};
    assign div_go = ((i_req.op == ALU_DIV) || (i_req.op == ALU_MOD)) && (i_b != 32'd0);

    always_comb begin
        unique case (i_req.op)
            ALU_EQ:  cmp_flag = (i_a == i_b);
            ALU_NE:  cmp_flag = (i_a != i_b);
            ALU_LT:  cmp_flag = ($signed(i_a) < $signed(i_b));
            ALU_GT:  cmp_flag = ($signed(i_a) > $signed(i_b));
            ALU_LE:  cmp_flag = ($signed(i_a) <= $signed(i_b));
            ALU_GE:  cmp_flag = ($signed(i_a) >= $signed(i_b));
            default: cmp_flag = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    r_done <= i_req.start && !div_go;
                    if (i_req.start && div_go) begin
                        r_state <= A_DIV;
                    end
                end
                A_DIV: begin
                    r_done <= 1'b0;
                    if (r_cnt == 5'd31) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_flag <= cmp_flag;
                    unique case (i_req.op)
                        ALU_ADD: r_res <= i_a + i_b;
                        ALU_SUB: r_res <= i_a - i_b;
                        ALU_MUL: r_res <= i_a * i_b;
                        ALU_DIV, ALU_MOD: begin
                            // divide by zero: quotient all ones, remainder is the dividend
                            r_res    <= (i_req.op == ALU_MOD) ? i_a : '1;
                            r_is_mod <= (i_req.op == ALU_MOD);
                            r_neg_q  <= i_a[31] ^ i_b[31];
                            r_neg_r  <= i_a[31];
                            r_quo    <= abs_a;
                            r_dvs    <= abs_b;
                            r_rem    <= '0;
                            r_cnt    <= '0;
                        end
                        default: r_res <= '0;
                    endcase
                end
            end
            A_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 5'd1;
            end
            A_FIX: begin
                if (r_is_mod) begin
                    r_res <= r_neg_r ? (32'd0 - r_rem) : r_rem;
                end else begin
                    r_res <= r_neg_q ? (32'd0 - r_quo) : r_quo;
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.flag = r_flag;
    assign o_result   = r_res;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == A_IDLE)
        else $error("alu started while busy");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_DIV && r_cnt == 5'd31) |=> r_state == A_FIX)
        else $error("divide did not finish after 32 steps");
`endif

endmodule

// ----- hdl/register_vm_execute_unit.sv -----
// sequence: a request is taken in idle and its registers are read; li, mov, jumps, sys, nop and
// unknown opcodes then finish, while add, sub, mul, compare-branches, div and mod wait on the alu
// (div and mod by nonzero take 32 divider steps); a request ignored once halted skips the read
// throughput: one request at a time; the next request is taken the cycle after
// the result is loaded, and a held result stalls completion of the next one
// reset (synchronous, active low): registers read as zero, pc 0, not halted, length 0
module register_vm_execute_unit
    import rvm_pkg::*;
#(
    parameter int unsigned PROGRAM_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_rsp    o_out_rsp
);

    localparam logic [16:0] LIMIT_CAP = 17'(PROGRAM_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_ALU  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  r_state;
    logic [16:0] r_prog_len;
    logic [15:0] r_pc;
    logic        r_stopped;
    t_in_req     r_req;
    logic        r_ign;
    logic [31:0] r_target;
    logic        r_wen;
    logic [31:0] r_wdata;
    logic        r_pvalid;
    logic [4:0]  r_preg;
    logic [31:0] r_pval;
    logic        r_unknown;
    logic        r_out_valid;
    t_out_rsp    r_out;

    logic [16:0] limit;
    logic        in_acc;
    logic        out_free;
    logic        halt;
    logic        is_arith;
    logic        is_br_imm;
    logic        is_br_reg;
    logic        in_is_br;
    logic        in_is_jr;
    logic [31:0] pc_inc;
    t_rf_ctl     rf_ctl;
    logic [31:0] rf_rd0;
    logic [31:0] rf_rd1;
    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;
    logic [31:0] alu_res;

    function automatic logic [3:0] alu_op_of(input logic [7:0] cmd);
        logic [3:0] op;
        unique case (cmd)
            OPC_SUB:            op = ALU_SUB;
            OPC_MUL:            op = ALU_MUL;
            OPC_DIV:            op = ALU_DIV;
            OPC_MOD:            op = ALU_MOD;
            OPC_JEQ, OPC_JREQ:  op = ALU_EQ;
            OPC_JNE, OPC_JRNE:  op = ALU_NE;
            OPC_JLT, OPC_JRLT:  op = ALU_LT;
            OPC_JGT, OPC_JRGT:  op = ALU_GT;
            OPC_JLE, OPC_JRLE:  op = ALU_LE;
            OPC_JGE, OPC_JRGE:  op = ALU_GE;
            default:            op = ALU_ADD;
        endcase
        return op;
    endfunction

    assign limit     = (r_prog_len > LIMIT_CAP) ? LIMIT_CAP : r_prog_len;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pc_inc    = 32'(r_pc) + 32'd1;
    assign halt      = r_ign || (r_target >= 32'(limit));

    assign is_arith  = (r_req.cmd >= OPC_ADD) && (r_req.cmd <= OPC_MOD);
    assign is_br_imm = (r_req.cmd >= OPC_JEQ) && (r_req.cmd <= OPC_JGE);
    assign is_br_reg = (r_req.cmd >= OPC_JREQ) && (r_req.cmd <= OPC_JRGE);
    assign in_is_br  = ((i_in_req.cmd >= OPC_JEQ) && (i_in_req.cmd <= OPC_JGE))
                    || ((i_in_req.cmd >= OPC_JREQ) && (i_in_req.cmd <= OPC_JRGE));
    assign in_is_jr  = (i_in_req.cmd == OPC_JR);

    // register file access
    always_comb begin
        rf_ctl          = '0;
        rf_ctl.rd0_addr = (in_is_br || in_is_jr) ? i_in_req.field_a[4:0] : i_in_req.field_b[4:0];
        rf_ctl.rd1_addr = in_is_br ? i_in_req.field_b[4:0] : i_in_req.field_c[4:0];
        rf_ctl.wr_addr  = r_req.field_a[4:0];
        if (r_state == S_IDLE) begin
            rf_ctl.rd0_en = in_acc;
            rf_ctl.rd1_en = in_acc;
        end else if (r_state == S_RD && is_br_reg) begin
            // branch target register
            rf_ctl.rd0_en   = 1'b1;
            rf_ctl.rd0_addr = r_req.field_c[4:0];
        end
        rf_ctl.wr_en = (r_state == S_DONE) && out_free && r_wen;
    end

    assign alu_req.start = (r_state == S_RD) && (is_arith || is_br_imm || is_br_reg);
    assign alu_req.op    = alu_op_of(r_req.cmd);

    rvm_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rf_ctl),
        .i_wdata  (r_wdata),
        .o_rdata0 (rf_rd0),
        .o_rdata1 (rf_rd1)
    );

    rvm_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (rf_rd0),
        .i_b      (rf_rd1),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
        end else if (i_cfg_we) begin
            r_prog_len <= i_cfg_wdata;
        end
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= (r_stopped || (17'(r_pc) >= limit)) ? S_DONE : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= (is_arith || is_br_imm || is_br_reg) ? S_ALU : S_DONE;
                end
                S_ALU: begin
                    if (alu_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (halt) begin
                            r_stopped <= 1'b1;
                        end else begin
                            r_pc <= r_target[15:0];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request payload and results
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_req     <= i_in_req;
                    r_ign     <= r_stopped || (17'(r_pc) >= limit);
                    r_target  <= pc_inc;
                    r_wen     <= 1'b0;
                    r_pvalid  <= 1'b0;
                    r_preg    <= '0;
                    r_pval    <= '0;
                    r_unknown <= 1'b0;
                end
            end
            S_RD: begin
                priority if (r_req.cmd == OPC_LI) begin
                    r_wen   <= 1'b1;
                    r_wdata <= {{16{r_req.field_c[7]}}, r_req.field_c, r_req.field_b};
                end else if (r_req.cmd == OPC_J) begin
                    r_target <= 32'(r_req.field_a);
                end else if (r_req.cmd == OPC_JR) begin
                    r_target <= rf_rd0;
                end else if (r_req.cmd == OPC_MOV) begin
                    r_wen   <= 1'b1;
                    r_wdata <= rf_rd0;
                end else if (r_req.cmd == OPC_SYS) begin
                    if (r_req.field_a == SYS_PRINT) begin
                        r_pvalid <= 1'b1;
                        r_preg   <= r_req.field_b[4:0];
                        r_pval   <= rf_rd0;
                    end
                end else if (r_req.cmd > OPC_SYS) begin
                    r_unknown <= 1'b1;
                end else begin
                    r_wen <= 1'b0;
                end
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    if (is_arith) begin
                        r_wen   <= 1'b1;
                        r_wdata <= alu_res;
                    end else if (alu_rsp.flag) begin
                        r_target <= is_br_imm ? 32'(r_req.field_c) : rf_rd0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.next_pc     <= halt ? r_pc : r_target[15:0];
                    r_out.halted      <= halt;
                    r_out.print_valid <= r_pvalid;
                    r_out.print_reg   <= r_preg;
                    r_out.print_value <= r_pval;
                    r_out.unknown_op  <= r_unknown;
                end
            end
            default: begin
                r_wen <= 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef NO_ASSERTIONS
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("halt cleared without reset");

    a_pc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.halted) |-> (17'(o_out_rsp.next_pc) < limit))
        else $error("running with next pc out of range");

    a_print_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.print_valid)
            |-> (o_out_rsp.print_reg == 5'd0 && o_out_rsp.print_value == 32'sd0))
        else $error("print fields set without print");

    a_print_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.print_valid) |-> !o_out_rsp.unknown_op)
        else $error("print reported on unknown opcode");
`endif

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    import rvm_pkg::*;

    localparam int DEPTH          = 256;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 80;

    class exec_scoreboard;
        logic [31:0] regs [NUM_REGS];
        logic [15:0] pc;
        bit          stopped;
        logic [16:0] length;
        int          depth;
        int          errors;
        t_out_rsp    pending_results [$];

        function new(int d);
            foreach (regs[i]) regs[i] = '0;
            pc      = '0;
            stopped = 1'b0;
            length  = '0;
            depth   = d;
            errors  = 0;
        endfunction

        function void set_length(logic [16:0] v);
            length = v;
        endfunction

        function int limit();
            return (length > depth) ? depth : int'(length);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function bit taken(logic [7:0] cmd, logic signed [31:0] a, logic signed [31:0] b);
            case (cmd)
                OPC_JEQ, OPC_JREQ: return a == b;
                OPC_JNE, OPC_JRNE: return a != b;
                OPC_JLT, OPC_JRLT: return a < b;
                OPC_JGT, OPC_JRGT: return a > b;
                OPC_JLE, OPC_JRLE: return a <= b;
                default:           return a >= b;
            endcase
        endfunction

        // quotient in the upper half, remainder in the lower half
        function logic [63:0] divide(logic [31:0] x, logic [31:0] y);
            logic [31:0] mx, my, uq, ur, q, r;
            if (y == '0) return {32'hFFFF_FFFF, x};
            if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) return {x, 32'h0};
            mx = x[31] ? -x : x;
            my = y[31] ? -y : y;
            uq = mx / my;
            ur = mx % my;
            q  = (x[31] ^ y[31]) ? -uq : uq;
            r  = x[31] ? -ur : ur;
            return {q, r};
        endfunction

        function t_out_rsp execute(t_in_req rq);
            t_out_rsp    o;
            logic [31:0] lim, tgt, x, y;
            logic [63:0] qr;
            logic [4:0]  ia, ib, ic;
            bit          neg;
            o   = '0;
            lim = limit();
            tgt = {16'h0, pc} + 32'd1;
            neg = 1'b0;
            ia  = rq.field_a[4:0];
            ib  = rq.field_b[4:0];
            ic  = rq.field_c[4:0];
            if (stopped || pc >= lim) begin
                stopped = 1'b1;
            end else begin
                x = regs[ib];
                y = regs[ic];
                case (rq.cmd)
                    OPC_NOP: ;
                    OPC_LI: regs[ia] = {{16{rq.field_c[7]}}, rq.field_c, rq.field_b};
                    OPC_ADD: regs[ia] = x + y;
                    OPC_SUB: regs[ia] = x - y;
                    OPC_MUL: regs[ia] = x * y;
                    OPC_DIV, OPC_MOD: begin
                        qr = divide(x, y);
                        regs[ia] = (rq.cmd == OPC_DIV) ? qr[63:32] : qr[31:0];
                    end
                    OPC_J: tgt = {24'h0, rq.field_a};
                    OPC_JEQ, OPC_JNE, OPC_JLT, OPC_JGT, OPC_JLE, OPC_JGE: begin
                        if (taken(rq.cmd, regs[ia], regs[ib])) tgt = {24'h0, rq.field_c};
                    end
                    OPC_JR: begin
                        tgt = regs[ia];
                        neg = tgt[31];
                    end
                    OPC_JREQ, OPC_JRNE, OPC_JRLT, OPC_JRGT, OPC_JRLE, OPC_JRGE: begin
                        if (taken(rq.cmd, regs[ia], regs[ib])) begin
                            tgt = regs[ic];
                            neg = tgt[31];
                        end
                    end
                    OPC_MOV: regs[ia] = x;
                    OPC_SYS: begin
                        if (rq.field_a == SYS_PRINT) begin
                            o.print_valid = 1'b1;
                            o.print_reg   = ib;
                            o.print_value = regs[ib];
                        end
                    end
                    default: o.unknown_op = 1'b1;
                endcase
                if (neg || tgt >= lim) stopped = 1'b1;
                else pc = tgt[15:0];
            end
            o.next_pc = pc;
            o.halted  = stopped;
            return o;
        endfunction

        function bit would_halt(t_in_req rq);
            logic [31:0] saved_regs [NUM_REGS];
            logic [15:0] saved_pc;
            bit          saved_stopped;
            t_out_rsp    o;
            saved_regs    = regs;
            saved_pc      = pc;
            saved_stopped = stopped;
            o             = execute(rq);
            regs          = saved_regs;
            pc            = saved_pc;
            stopped       = saved_stopped;
            return o.halted;
        endfunction

        function void note_request(t_in_req rq);
            pending_results.push_back(execute(rq));
        endfunction

        task report_mismatch(string msg);
            if (errors < 200) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_response(t_out_rsp got);
            t_out_rsp want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %h", got));
                return;
            end
            want = pending_results.pop_front();
            check_field("next_pc", got.next_pc, want.next_pc);
            check_field("halted", got.halted, want.halted);
            check_field("print_valid", got.print_valid, want.print_valid);
            check_field("print_reg", got.print_reg, want.print_reg);
            check_field("print_value", got.print_value, want.print_value);
            check_field("unknown_op", got.unknown_op, want.unknown_op);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [16:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in_req;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_rsp    o_out_rsp;

    exec_scoreboard sb;
    int sender_idle = 0;
    int stall_pct   = 0;
    int hold_gen    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    localparam logic [7:0] ARITH_OPS [5] = '{OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD};
    localparam logic [7:0] BRANCH_OPS [6] =
        '{OPC_JEQ, OPC_JNE, OPC_JLT, OPC_JGT, OPC_JLE, OPC_JGE};
    localparam logic [7:0] REG_JUMP_OPS [7] =
        '{OPC_JR, OPC_JREQ, OPC_JRNE, OPC_JRLT, OPC_JRGT, OPC_JRLE, OPC_JRGE};

    register_vm_execute_unit #(
        .PROGRAM_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_gen != hold_seen) begin
            hold_seen   <= hold_gen;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_length(i_cfg_wdata);
            if (o_out_valid && !i_out_stall) sb.check_response(o_out_rsp);
            if (i_in_valid && !o_in_stall) sb.note_request(i_in_req);
        end
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(t_in_req rq);
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= rq;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_length(logic [16:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in_req random_instr(int lim);
        t_in_req rq;
        int      pick;
        logic [15:0] imm;
        rq   = t_in_req'($urandom);
        pick = $urandom_range(99);
        if (pick < 12) begin
            rq.cmd = OPC_LI;
            if ($urandom_range(1)) begin
                imm = 16'($urandom_range(lim - 1));
                {rq.field_c, rq.field_b} = imm;
            end
        end else if (pick < 40) begin
            rq.cmd = ARITH_OPS[$urandom_range(4)];
        end else if (pick < 48) begin
            rq.cmd = OPC_MOV;
        end else if (pick < 54) begin
            rq.cmd     = OPC_J;
            rq.field_a = 8'($urandom_range(lim - 1));
        end else if (pick < 66) begin
            rq.cmd = BRANCH_OPS[$urandom_range(5)];
            if ($urandom_range(3) != 0) rq.field_c = 8'($urandom_range(lim - 1));
        end else if (pick < 78) begin
            rq.cmd = REG_JUMP_OPS[$urandom_range(6)];
        end else if (pick < 86) begin
            rq.cmd = OPC_SYS;
            if ($urandom_range(3) != 0) rq.field_a = SYS_PRINT;
        end else if (pick < 90) begin
            rq.cmd = OPC_NOP;
        end else begin
            rq.cmd = 8'($urandom_range(255, OPC_SYS + 1));
        end
        return rq;
    endfunction

    // keeps the program alive: candidates that would halt are redrawn
    function automatic t_in_req next_instr();
        t_in_req rq;
        int      lim;
        lim = sb.limit();
        for (int k = 0; k < 16; k++) begin
            rq = random_instr(lim);
            if (!sb.would_halt(rq)) return rq;
        end
        return {OPC_J, 8'($urandom_range(lim - 1)), 8'($urandom), 8'($urandom)};
    endfunction

    task automatic jump_home();
        send_request({OPC_J, 8'h00, 8'($urandom), 8'($urandom)});
    endtask

    task automatic run_directed();
        t_in_req seq [24] = '{
            {OPC_LI,  8'h01, 8'h00, 8'h80},
            {OPC_LI,  8'h24, 8'hFF, 8'hFF},
            {OPC_LI,  8'hE8, 8'hFF, 8'h7F},
            {OPC_MUL, 8'h02, 8'h01, 8'h01},
            {OPC_ADD, 8'h03, 8'h02, 8'h02},
            {OPC_DIV, 8'h05, 8'h03, 8'h04},
            {OPC_MOD, 8'h06, 8'h03, 8'h04},
            {OPC_DIV, 8'h07, 8'h08, 8'h09},
            {OPC_MOD, 8'h0A, 8'h08, 8'h09},
            {OPC_SUB, 8'h0B, 8'h09, 8'h08},
            {OPC_DIV, 8'h0C, 8'h03, 8'h08},
            {OPC_MOV, 8'h0F, 8'hE3, 8'h00},
            {OPC_SYS, SYS_PRINT, 8'h03, 8'h00},
            {OPC_SYS, 8'hFF, 8'h03, 8'h00},
            {8'hFF,   8'hFF, 8'hFF, 8'hFF},
            {OPC_SYS + 8'd1, 8'h00, 8'h00, 8'h00},
            {OPC_NOP, 8'h00, 8'h00, 8'h00},
            {OPC_J,   8'd30, 8'h00, 8'h00},
            {OPC_JEQ, 8'h09, 8'h00, 8'd40},
            {OPC_JLT, 8'h01, 8'h08, 8'd50},
            {OPC_JGT, 8'h03, 8'h08, 8'd60},
            {OPC_LI,  8'h10, 8'd100, 8'h00},
            {OPC_JR,  8'h10, 8'h00, 8'h00},
            {OPC_JRGE, 8'h08, 8'h04, 8'h10}
        };
        write_length(17'd65536);
        foreach (seq[i]) send_request(seq[i]);
        jump_home();
        drain();
    endtask

    task automatic run_phase(logic [16:0] len, int idle, int stall, bit pressure);
        write_length(len);
        sender_idle = idle;
        stall_pct   = stall;
        if (pressure) hold_gen++;
        repeat (PHASE_ITEMS) send_request(next_instr());
        jump_home();
        drain();
    endtask

    // runs the program off its end, then feeds a stopped unit
    task automatic run_halt();
        int         lim;
        logic [4:0] rx;
        write_length(17'($urandom_range(256, 2)));
        sender_idle = 26;
        stall_pct   = 26;
        lim = sb.limit();
        rx  = 5'($urandom);
        case ($urandom_range(2))
            0: begin
                send_request({OPC_J, 8'(lim - 1), 8'($urandom), 8'($urandom)});
                send_request({OPC_SYS, SYS_PRINT, 8'($urandom), 8'($urandom)});
            end
            1: begin
                send_request({OPC_LI, 3'($urandom), rx, 8'hFB, 8'hFF});
                send_request({OPC_JR, 3'($urandom), rx, 8'($urandom), 8'($urandom)});
            end
            default: begin
                send_request({OPC_LI, 3'($urandom), rx, 8'h2C, 8'h01});
                send_request({OPC_JR, 3'($urandom), rx, 8'($urandom), 8'($urandom)});
            end
        endcase
        repeat (4) send_request(t_in_req'($urandom));
        drain();
        write_length('0);
        repeat (3) send_request(t_in_req'($urandom));
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        sb = new(DEPTH);
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        run_phase(17'd256, 0, 0, 1'b0);
        run_phase(17'd1, 56, 0, 1'b0);
        run_phase(17'd2, 0, 56, 1'b0);
        run_phase(17'($urandom_range(65536, 3)), 26, 26, 1'b0);
        run_phase(17'd65535, 0, 0, 1'b1);
        run_halt();

        repeat (50) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
